FILE: rtl/per_channel_requantize_int8_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for per_channel_requantize_int8
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_REQUANTIZE_INT8_ASSERT_SVH
`define PER_CHANNEL_REQUANTIZE_INT8_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RQNT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("requantizer check failed");

// Next-cycle implication.
`define RQNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("requantizer check failed");

`else

`define RQNT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RQNT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/rqnt_pkg.sv
// ----------------------------------------------------------------------------
// rqnt_pkg
// Shared constants and types of the per-channel int8 requantizer.
// ----------------------------------------------------------------------------
package rqnt_pkg;

    localparam int MAX_CHANNELS       = 256;
    localparam int MAX_PLANE_ELEMENTS = 65536;

    localparam int TBL_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int POS_W  = (MAX_PLANE_ELEMENTS > 1) ? $clog2(MAX_PLANE_ELEMENTS) : 1;
    localparam int CH_CAP = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

    localparam int QMIN = -128;
    localparam int QMAX = 127;

    // Request kind, carried on s_tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    typedef enum logic [7:0] {
        CFG_OUT_OFFSET     = 8'd0,
        CFG_RELU_ENABLE    = 8'd1,
        CFG_ELEMS_PER_CHAN = 8'd2,
        CFG_CHANNEL_COUNT  = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [4:0]  shift;
        logic [30:0] mult;
    } scale_t;

    // Sideband that rides along with an accumulator through the pipeline.
    typedef struct packed {
        logic [7:0] channel;
        logic       last_ch;
        logic       last_t;
    } tag_t;

    typedef struct packed {
        logic signed [7:0] out_offset;
        logic              relu;
    } post_cfg_t;

endpackage

FILE: rtl/rqnt_scaler.sv
// ----------------------------------------------------------------------------
// rqnt_scaler
// Multiply, round-half-even shift, relu, zero point and int8 saturation.
// Three register stages, all advanced by one enable.
// ----------------------------------------------------------------------------
module rqnt_scaler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic               in_neg,
    input  logic [31:0]        in_mag,
    input  rqnt_pkg::scale_t   in_scale,
    input  rqnt_pkg::tag_t     in_tag,
    input  rqnt_pkg::post_cfg_t post_cfg,
    output logic               out_valid,
    output logic signed [7:0]  out_value,
    output rqnt_pkg::tag_t     out_tag
);

    // stage 2: product
    logic             v2_reg;
    logic             neg2_reg;
    logic [62:0]      prod2_reg;
    logic [4:0]       shf2_reg;
    rqnt_pkg::tag_t   tag2_reg;

    // stage 3: rounded magnitude
    logic             v3_reg;
    logic             neg3_reg;
    logic [31:0]      q3_reg;
    rqnt_pkg::tag_t   tag3_reg;

    // stage 4: output register
    logic             v4_reg;
    logic signed [7:0] val4_reg;
    rqnt_pkg::tag_t   tag4_reg;

    logic [62:0]      prod2_next;
    logic [5:0]       s3;
    logic [62:0]      shifted3;
    logic [62:0]      low_mask3;
    logic             guard3;
    logic             sticky3;
    logic [31:0]      q3_next;
    logic signed [33:0] sv4;
    logic signed [33:0] sum4;
    logic signed [7:0]  val4_next;

    assign prod2_next = {31'b0, in_mag} * {32'b0, in_scale.mult};

    // shift by 31 + shift, round half to even
    always_comb
    begin
        s3        = 6'd31 + {1'b0, shf2_reg};
        shifted3  = prod2_reg >> s3;
        low_mask3 = (63'd1 << 6'(s3 - 6'd1)) - 63'd1;
        guard3    = prod2_reg[6'(s3 - 6'd1)];
        sticky3   = |(prod2_reg & low_mask3);
        q3_next   = shifted3[31:0] + {31'b0, guard3 & (sticky3 | shifted3[0])};
    end

    always_comb
    begin
        sv4 = neg3_reg ? -$signed({2'b00, q3_reg}) : $signed({2'b00, q3_reg});
        if (post_cfg.relu && sv4 < 0)
        begin
            sv4 = '0;
        end
        sum4 = sv4 + {{26{post_cfg.out_offset[7]}}, post_cfg.out_offset};
        if (sum4 < 34'(rqnt_pkg::QMIN))
        begin
            val4_next = 8'(rqnt_pkg::QMIN);
        end
        else if (sum4 > 34'(rqnt_pkg::QMAX))
        begin
            val4_next = 8'(rqnt_pkg::QMAX);
        end
        else
        begin
            val4_next = sum4[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg  <= in_neg;
            prod2_reg <= prod2_next;
            shf2_reg  <= in_scale.shift;
            tag2_reg  <= in_tag;
            neg3_reg  <= neg2_reg;
            q3_reg    <= q3_next;
            tag3_reg  <= tag2_reg;
            val4_reg  <= val4_next;
            tag4_reg  <= tag3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_value = val4_reg;
    assign out_tag   = tag4_reg;

endmodule

FILE: rtl/per_channel_requantize_int8.sv
// ----------------------------------------------------------------------------
// per_channel_requantize_int8
// Per-channel requantization of int32 accumulators to saturated int8.
// ----------------------------------------------------------------------------
// Takes one request per cycle and keeps taking them back to back while
// the output is not stalled; a data request's int8 result goes through
// the operand and table read, multiply, round and saturate steps, a
// scale load yields nothing. The scale table has one write and one read
// port and every request touches it once, so the rate is one request per
// clock. A load writes its table entry at the accepting edge, so a data
// request that follows on the very next cycle already reads the new
// scale. While a result waits with m_tready low the whole pipeline
// freezes and s_tready drops. Accumulators arrive channel-major; the
// channel and the element position are counted here. Table entries never
// loaded give undefined results; there is no clearing pass after reset.
// The user must write configuration only while no request is in flight;
// the block does not enforce this.
// ----------------------------------------------------------------------------
`include "per_channel_requantize_int8_assert.svh"

module per_channel_requantize_int8 (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // scale_channel[7:0], scale_multiplier[38:8],
                                   // scale_shift[43:39], accumulator[75:44], zero pad
    input  logic        s_tuser,   // func: 0 load scale, 1 requantize
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // quantized_value[7:0], result_channel[15:8]
    output logic        m_tlast,   // last_in_channel
    output logic        m_tuser,   // last_in_tensor
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic signed [7:0] zp_reg;
    logic              relu_reg;
    logic [16:0]       epc_reg;
    logic [8:0]        cc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zp_reg   <= '0;
            relu_reg <= 1'b0;
            epc_reg  <= 17'd1;
            cc_reg   <= 9'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rqnt_pkg::cfg_index_t'(cfg_index))
                rqnt_pkg::CFG_OUT_OFFSET:     zp_reg   <= cfg_data[7:0];
                rqnt_pkg::CFG_RELU_ENABLE:    relu_reg <= cfg_data[0];
                rqnt_pkg::CFG_ELEMS_PER_CHAN: epc_reg  <= cfg_data;
                rqnt_pkg::CFG_CHANNEL_COUNT:  cc_reg   <= cfg_data[8:0];
                default:                      ;   // unknown index ignored
            endcase
        end
    end

    // ---------------- request unpacking ----------------
    logic [7:0]  in_channel;
    logic [30:0] in_mult;
    logic [4:0]  in_shift;
    logic [31:0] in_acc;

    assign in_channel = s_tdata[7:0];
    assign in_mult    = s_tdata[38:8];
    assign in_shift   = s_tdata[43:39];
    assign in_acc     = s_tdata[75:44];

    // ---------------- pipeline control ----------------
    // One enable for every stage; the output register is the last stage.
    logic pipe_en;
    logic out_valid;
    logic accept;
    logic load_acc;
    logic data_acc;

    assign pipe_en  = !out_valid || m_tready;
    assign s_tready = pipe_en;
    assign accept   = s_tvalid && s_tready;
    assign load_acc = accept && (s_tuser == rqnt_pkg::FUNC_LOAD);
    assign data_acc = accept && (s_tuser == rqnt_pkg::FUNC_DATA);

    // ---------------- channel / element tracking ----------------
    logic [rqnt_pkg::POS_W-1:0] pos_reg;
    logic [7:0]                 ch_reg;
    logic [16:0]                epc_m1;
    logic [7:0]                 cc_m1;
    logic                       last_ch;
    logic                       last_t;

    // Plane length clamped to [1, MAX_PLANE_ELEMENTS], count to [1, CH_CAP].
    always_comb
    begin
        if (epc_reg == '0)
        begin
            epc_m1 = '0;
        end
        else if (int'(epc_reg) > rqnt_pkg::MAX_PLANE_ELEMENTS)
        begin
            epc_m1 = 17'(rqnt_pkg::MAX_PLANE_ELEMENTS - 1);
        end
        else
        begin
            epc_m1 = epc_reg - 17'd1;
        end

        if (cc_reg == '0)
        begin
            cc_m1 = '0;
        end
        else if (int'(cc_reg) > rqnt_pkg::CH_CAP)
        begin
            cc_m1 = 8'(rqnt_pkg::CH_CAP - 1);
        end
        else
        begin
            cc_m1 = 8'(cc_reg - 9'd1);
        end

        // "at or beyond" so that a mid-tensor register change still wraps
        last_ch = 32'(pos_reg) >= 32'(epc_m1);
        last_t  = last_ch && (ch_reg >= cc_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ch_reg  <= '0;
        end
        else if (data_acc)
        begin
            if (last_ch)
            begin
                pos_reg <= '0;
                ch_reg  <= last_t ? 8'd0 : ch_reg + 8'd1;
            end
            else
            begin
                pos_reg <= pos_reg + rqnt_pkg::POS_W'(1);
            end
        end
    end

    // ---------------- scale table ----------------
    // Synchronous memory with a registered read. A load writes at its
    // accepting edge; the read for a data request is taken at its own
    // accepting edge, so the two never meet on the same entry in one cycle.
    rqnt_pkg::scale_t scale_mem [rqnt_pkg::MAX_CHANNELS];
    rqnt_pkg::scale_t scale_rd_reg;
    logic             load_in_range;

    assign load_in_range = int'(in_channel) < rqnt_pkg::MAX_CHANNELS;

    always_ff @(posedge clk)
    begin
        if (load_acc && load_in_range)
        begin
            scale_mem[in_channel[rqnt_pkg::TBL_AW-1:0]] <= '{shift: in_shift, mult: in_mult};
        end
        if (pipe_en)
        begin
            scale_rd_reg <= scale_mem[ch_reg[rqnt_pkg::TBL_AW-1:0]];
        end
    end

    // ---------------- stage 1: operand register ----------------
    // Sign and magnitude split here; |-2^31| still fits in 32 unsigned bits.
    logic           v1_reg;
    logic           neg1_reg;
    logic [31:0]    mag1_reg;
    rqnt_pkg::tag_t tag1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= data_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            neg1_reg <= in_acc[31];
            mag1_reg <= in_acc[31] ? (32'd0 - in_acc) : in_acc;
            tag1_reg <= '{channel: ch_reg, last_ch: last_ch, last_t: last_t};
        end
    end

    // ---------------- stages 2..4: arithmetic ----------------
    rqnt_pkg::post_cfg_t post_cfg;
    logic signed [7:0]   out_value;
    rqnt_pkg::tag_t      out_tag;

    assign post_cfg = '{out_offset: zp_reg, relu: relu_reg};

    rqnt_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v1_reg),
        .in_neg    (neg1_reg),
        .in_mag    (mag1_reg),
        .in_scale  (scale_rd_reg),
        .in_tag    (tag1_reg),
        .post_cfg  (post_cfg),
        .out_valid (out_valid),
        .out_value (out_value),
        .out_tag   (out_tag)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_tag.channel, out_value};
    assign m_tlast  = out_tag.last_ch;
    assign m_tuser  = out_tag.last_t;

    // ---------------- checks ----------------
    `RQNT_ASSERT_NOW(a_tensor_end_is_plane_end, clk, rst_n, m_tvalid && m_tuser, m_tlast)
    `RQNT_ASSERT_NEXT(a_plane_end_clears_pos, clk, rst_n, data_acc && last_ch, pos_reg == '0)
    `RQNT_ASSERT_NEXT(a_tensor_end_clears_ch, clk, rst_n, data_acc && last_t, ch_reg == '0)
    `RQNT_ASSERT_NEXT(a_stall_holds_stage1, clk, rst_n, v1_reg && !pipe_en, v1_reg)

endmodule
